// ===== design/ctbf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctbf_pkg: shared types and constants
// Constants, the queue item type and the scan phase type used by the front
// part, the back part and the top level of the boundary finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ctbf_pkg;

    localparam int MAX_SEQ_LEN = 4;
    localparam int ROLE_SEQS   = 3;
    localparam int PROBE_SKIPS = 5;
    localparam int MAX_PROMPT  = 65536;
    localparam int MAX_RESULTS = 8;

    localparam int NSEQ     = 1 + 2 * ROLE_SEQS;
    localparam int SEQ_ID_W = $clog2(NSEQ);
    localparam int LEN_W    = $clog2(MAX_SEQ_LEN + 1);
    localparam int IDX_W    = $clog2(ROLE_SEQS + 1);
    localparam int OFF_W    = $clog2(PROBE_SKIPS + 1);
    localparam int NRES_W   = $clog2(MAX_RESULTS);
    localparam int WIN_DEPTH = 16;
    localparam int WIN_AW   = 4;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam int TOK_W  = 20;
    localparam int POS_W  = 17;
    localparam int CNT_W  = 16;
    localparam int SET_W  = 2;
    localparam int MIDX_W = 2;
    localparam int MPOS_W = 2;
    localparam int MLEN_W = 3;

    localparam logic [SET_W-1:0] SET_SYS  = 2'd0;
    localparam logic [SET_W-1:0] SET_END  = 2'd1;
    localparam logic [SET_W-1:0] SET_ROLE = 2'd2;

    typedef enum logic [1:0] {
        PH_SYS   = 2'd0,
        PH_END   = 2'd1,
        PH_PROBE = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                is_load;
        logic                tok_wr;
        logic [SEQ_ID_W-1:0] seq_id;
        logic [MPOS_W-1:0]   mpos;
        logic [LEN_W-1:0]    mlen;
        logic [TOK_W-1:0]    token;
        logic                final_req;
        logic [POS_W-1:0]    restored_len;
    } t_item;

endpackage

// ===== design/ctbf_front.sv =====
// ----------------------------------------------------------------------------
// ctbf_front: input classification and item queue
// Accepts input items, decodes load targets into a table slot, drops loads
// with a bad target and holds the rest in a short queue for the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ctbf_front
    import ctbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [TOK_W-1:0]  i_token,
    input  logic [SET_W-1:0]  i_marker_set,
    input  logic [MIDX_W-1:0] i_marker_index,
    input  logic [MPOS_W-1:0] i_marker_pos,
    input  logic [MLEN_W-1:0] i_marker_len,
    input  logic              i_final_req,
    input  logic [POS_W-1:0]  i_restored_len,
    output logic              o_q_valid,
    output t_item             o_q_item,
    input  logic              i_q_pop
);

    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_cnt;
    logic [Q_AW:0]   n_cnt;

    t_item cls_item;
    logic  cls_keep;
    logic  accept;
    logic  push;

    assign o_in_stall = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && cls_keep;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_comb begin
        cls_item.is_load      = !i_mode;
        cls_item.tok_wr       = (int'(i_marker_pos) < MAX_SEQ_LEN);
        cls_item.seq_id       = '0;
        cls_item.mpos         = i_marker_pos;
        cls_item.mlen         = (int'(i_marker_len) > MAX_SEQ_LEN) ?
                                LEN_W'(MAX_SEQ_LEN) : LEN_W'(i_marker_len);
        cls_item.token        = i_token;
        cls_item.final_req    = i_final_req;
        cls_item.restored_len = i_restored_len;
        cls_keep              = 1'b1;
        if (!i_mode) begin
            case (i_marker_set)
                SET_SYS: begin
                    cls_keep = (i_marker_index == '0);
                end
                SET_END: begin
                    cls_keep        = (int'(i_marker_index) < ROLE_SEQS);
                    cls_item.seq_id = SEQ_ID_W'(1 + int'(i_marker_index));
                end
                SET_ROLE: begin
                    cls_keep        = (int'(i_marker_index) < ROLE_SEQS);
                    cls_item.seq_id = SEQ_ID_W'(1 + ROLE_SEQS + int'(i_marker_index));
                end
                default: begin
                    cls_keep = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_item;
        end
    end

endmodule

// ===== design/ctbf_back.sv =====
// ----------------------------------------------------------------------------
// ctbf_back: scan engine and result register
// Applies table loads, keeps the token window and settles one scan decision
// per cycle unless a new result meets a full registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ctbf_back
    import ctbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_is_summary,
    output logic [POS_W-1:0] o_boundary_pos,
    output logic [CNT_W-1:0] o_boundary_count,
    output logic [POS_W-1:0] o_snapshot_pos,
    output logic             o_system_found,
    output logic             o_run_end
);

    t_phase             r_phase, n_phase, it_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_cursor, n_cursor, it_cursor;
    logic [CNT_W-1:0]   r_count, n_count, it_count;
    logic [POS_W-1:0]   r_recent0, n_recent0, it_recent0;
    logic [POS_W-1:0]   r_recent1, n_recent1, it_recent1;
    logic [OFF_W-1:0]   r_off, n_off, it_off;
    logic [IDX_W-1:0]   r_idx, n_idx, it_idx;
    logic               r_active, n_active;
    logic               r_sys_chk, n_sys_chk, it_sys_chk;
    logic [NRES_W-1:0]  r_nres, n_nres, it_nres;
    logic               r_final;
    logic [POS_W-1:0]   r_restored;
    logic [LEN_W-1:0]   r_mlen [NSEQ];
    logic [TOK_W-1:0]   r_mtok [NSEQ*MAX_SEQ_LEN];
    logic [TOK_W-1:0]   r_win [WIN_DEPTH];

    logic               r_out_valid, n_out_valid;
    logic               r_o_summ, n_o_summ;
    logic [POS_W-1:0]   r_o_bpos, n_o_bpos;
    logic [CNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [POS_W-1:0]   r_o_snap, n_o_snap;
    logic               r_o_sys, n_o_sys;

    logic [POS_W:0]     base_full;
    logic [WIN_AW-1:0]  base;
    logic [TOK_W-1:0]   w_rd [MAX_SEQ_LEN];
    logic [NSEQ-1:0]    seq_hit;
    logic [POS_W:0]     cur_x, n_x, p_x;
    logic               it_ret, want_emit;
    logic [POS_W-1:0]   b_val;
    logic               end_hit, undec, stop;
    logic [LEN_W-1:0]   hit_len, role_len;
    logic               role_hit;
    logic               out_free, stall_it, do_iter, do_summ, win_wr;
    logic [POS_W-1:0]   target, snap;

    assign cur_x = {1'b0, r_cursor};
    assign n_x   = {1'b0, r_pos};
    assign p_x   = cur_x + (POS_W+1)'(r_off);

    always_comb begin
        case (r_phase)
            PH_SYS:   base_full = n_x - (POS_W+1)'(r_mlen[0]);
            PH_PROBE: base_full = p_x;
            default:  base_full = cur_x;
        endcase
        base = base_full[WIN_AW-1:0];
        for (int t = 0; t < MAX_SEQ_LEN; t++) begin
            w_rd[t] = r_win[base + WIN_AW'(t)];
        end
        for (int s = 0; s < NSEQ; s++) begin
            seq_hit[s] = 1'b1;
            for (int t = 0; t < MAX_SEQ_LEN; t++) begin
                if ((LEN_W'(t) < r_mlen[s]) && (w_rd[t] != r_mtok[s*MAX_SEQ_LEN+t])) begin
                    seq_hit[s] = 1'b0;
                end
            end
        end
        role_len = '0;
        role_hit = 1'b0;
        for (int i = 0; i < ROLE_SEQS; i++) begin
            if (r_idx == IDX_W'(i)) begin
                role_len = r_mlen[1+ROLE_SEQS+i];
                role_hit = seq_hit[1+ROLE_SEQS+i];
            end
        end
    end

    // One scan decision on the current state.
    always_comb begin
        it_phase   = r_phase;
        it_cursor  = r_cursor;
        it_count   = r_count;
        it_recent0 = r_recent0;
        it_recent1 = r_recent1;
        it_off     = r_off;
        it_idx     = r_idx;
        it_sys_chk = r_sys_chk;
        it_nres    = r_nres;
        it_ret     = 1'b0;
        want_emit  = 1'b0;
        b_val      = '0;
        end_hit    = 1'b0;
        undec      = 1'b0;
        stop       = 1'b0;
        hit_len    = '0;
        case (r_phase)
            PH_SYS: begin
                it_sys_chk = 1'b0;
                if (r_sys_chk && (r_mlen[0] != '0) && (r_pos >= POS_W'(r_mlen[0]))
                        && seq_hit[0]) begin
                    it_cursor = r_pos;
                    it_phase  = PH_END;
                end else begin
                    it_ret = 1'b1;
                end
            end
            PH_END: begin
                if (r_cursor >= r_pos) begin
                    it_ret = 1'b1;
                    if (r_final) begin
                        it_phase = PH_DONE;
                    end
                end else begin
                    for (int i = 0; i < ROLE_SEQS; i++) begin
                        if (!stop && (r_mlen[1+i] != '0)) begin
                            if (cur_x + (POS_W+1)'(r_mlen[1+i]) > n_x) begin
                                if (!r_final) begin
                                    undec = 1'b1;
                                    stop  = 1'b1;
                                end
                            end else if (seq_hit[1+i]) begin
                                end_hit = 1'b1;
                                hit_len = r_mlen[1+i];
                                stop    = 1'b1;
                            end
                        end
                    end
                    if (end_hit) begin
                        it_cursor = r_cursor + POS_W'(hit_len);
                        it_off    = '0;
                        it_idx    = '0;
                        it_phase  = PH_PROBE;
                    end else if (undec) begin
                        it_ret = 1'b1;
                    end else begin
                        it_cursor = r_cursor + 1'b1;
                    end
                end
            end
            PH_PROBE: begin
                if (r_off >= OFF_W'(PROBE_SKIPS)) begin
                    it_phase = PH_DONE;
                    it_ret   = 1'b1;
                end else if ((role_len != '0) && (p_x + (POS_W+1)'(role_len) > n_x)
                        && !r_final) begin
                    it_ret = 1'b1;
                end else if ((role_len != '0) && (p_x + (POS_W+1)'(role_len) <= n_x)
                        && role_hit) begin
                    b_val      = p_x[POS_W-1:0] + POS_W'(role_len);
                    it_count   = (r_count != '1) ? r_count + 1'b1 : r_count;
                    it_recent1 = r_recent0;
                    it_recent0 = b_val;
                    it_cursor  = b_val;
                    it_phase   = PH_END;
                    if (r_nres < NRES_W'(MAX_RESULTS - 1)) begin
                        want_emit = 1'b1;
                        it_nres   = r_nres + 1'b1;
                    end
                end else if (r_idx == IDX_W'(ROLE_SEQS - 1)) begin
                    it_idx = '0;
                    it_off = r_off + 1'b1;
                end else begin
                    it_idx = r_idx + 1'b1;
                end
            end
            default: begin
                it_ret = 1'b1;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign stall_it = (want_emit || (it_ret && r_final)) && !out_free;
    assign do_iter  = r_active && !stall_it;
    assign do_summ  = do_iter && it_ret && r_final;
    assign o_q_pop  = i_q_valid && (!r_active || (do_iter && it_ret && !r_final));
    assign win_wr   = o_q_pop && !i_q_item.is_load && (int'(r_pos) < MAX_PROMPT);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_cursor  = r_cursor;
        n_count   = r_count;
        n_recent0 = r_recent0;
        n_recent1 = r_recent1;
        n_off     = r_off;
        n_idx     = r_idx;
        n_active  = r_active;
        n_sys_chk = r_sys_chk;
        n_nres    = r_nres;
        if (do_iter) begin
            n_phase   = it_phase;
            n_cursor  = it_cursor;
            n_count   = it_count;
            n_recent0 = it_recent0;
            n_recent1 = it_recent1;
            n_off     = it_off;
            n_idx     = it_idx;
            n_sys_chk = it_sys_chk;
            n_nres    = it_nres;
            if (it_ret) begin
                n_active = 1'b0;
            end
        end
        if (do_summ) begin
            n_phase   = PH_SYS;
            n_pos     = '0;
            n_cursor  = '0;
            n_count   = '0;
            n_recent0 = '0;
            n_recent1 = '0;
            n_off     = '0;
            n_idx     = '0;
            n_sys_chk = 1'b0;
        end
        if (o_q_pop && !i_q_item.is_load) begin
            n_active = 1'b1;
            n_nres   = '0;
            if (win_wr) begin
                n_pos     = r_pos + 1'b1;
                n_sys_chk = 1'b1;
            end
        end
    end

    always_comb begin
        target = '0;
        if (r_count >= CNT_W'(2)) begin
            target = r_recent1;
        end else if (r_count == CNT_W'(1)) begin
            target = r_recent0;
        end
        snap = ((r_count != '0) && (target > r_restored)) ? target : '0;
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_o_summ    = r_o_summ;
        n_o_bpos    = r_o_bpos;
        n_o_cnt     = r_o_cnt;
        n_o_snap    = r_o_snap;
        n_o_sys     = r_o_sys;
        if (do_iter && want_emit) begin
            n_out_valid = 1'b1;
            n_o_summ    = 1'b0;
            n_o_bpos    = b_val;
            n_o_cnt     = it_count;
            n_o_snap    = '0;
            n_o_sys     = 1'b1;
        end else if (do_summ) begin
            n_out_valid = 1'b1;
            n_o_summ    = 1'b1;
            n_o_bpos    = '0;
            n_o_cnt     = r_count;
            n_o_snap    = snap;
            n_o_sys     = (it_phase != PH_SYS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYS;
            r_pos       <= '0;
            r_cursor    <= '0;
            r_count     <= '0;
            r_recent0   <= '0;
            r_recent1   <= '0;
            r_off       <= '0;
            r_idx       <= '0;
            r_active    <= 1'b0;
            r_sys_chk   <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NSEQ; s++) begin
                r_mlen[s] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_recent0   <= n_recent0;
            r_recent1   <= n_recent1;
            r_off       <= n_off;
            r_idx       <= n_idx;
            r_active    <= n_active;
            r_sys_chk   <= n_sys_chk;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
            if (o_q_pop && i_q_item.is_load) begin
                r_mlen[i_q_item.seq_id] <= i_q_item.mlen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_summ <= n_o_summ;
        r_o_bpos <= n_o_bpos;
        r_o_cnt  <= n_o_cnt;
        r_o_snap <= n_o_snap;
        r_o_sys  <= n_o_sys;
        if (o_q_pop && !i_q_item.is_load) begin
            r_final    <= i_q_item.final_req;
            r_restored <= i_q_item.restored_len;
        end
        if (win_wr) begin
            r_win[r_pos[WIN_AW-1:0]] <= i_q_item.token;
        end
        for (int s = 0; s < NSEQ; s++) begin
            for (int t = 0; t < MAX_SEQ_LEN; t++) begin
                if (o_q_pop && i_q_item.is_load && i_q_item.tok_wr
                        && (i_q_item.seq_id == SEQ_ID_W'(s)) && (int'(i_q_item.mpos) == t)) begin
                    r_mtok[s*MAX_SEQ_LEN+t] <= i_q_item.token;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_summary     = r_o_summ;
    assign o_boundary_pos   = r_o_bpos;
    assign o_boundary_count = r_o_cnt;
    assign o_snapshot_pos   = r_o_snap;
    assign o_system_found   = r_o_sys;
    assign o_run_end        = r_o_summ;

endmodule

// ===== design/chat_turn_boundary_finder_unit.sv =====
// ----------------------------------------------------------------------------
// chat_turn_boundary_finder_unit: chat turn boundary finder
// Loads a marker table and scans prompt tokens for turn boundaries.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one item per cycle, while the queue is not
// full, into a four-entry queue. A load item (mode 0) writes one marker table
// token and the length of its sequence; it gives no result. A prompt token
// (mode 1) is written into the token window, and the scan engine then settles
// one decision per cycle (one end-sequence test at the cursor or one role
// probe). A token that settles nothing is done with its first decision, so a
// steady stream runs at one item per cycle; each further settled decision
// delays the next item. Each boundary found gives a boundary result, up to
// seven per prompt token; the final token gives a summary with run_end set.
// A result is registered in the output register and waits there while the
// receiver stalls; the engine stops only when it has a new result for a full
// register, and the queue keeps taking items until it fills. Reset clears the
// scan state and all marker lengths at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chat_turn_boundary_finder_unit
    import ctbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [TOK_W-1:0]  i_token,
    input  logic [SET_W-1:0]  i_marker_set,
    input  logic [MIDX_W-1:0] i_marker_index,
    input  logic [MPOS_W-1:0] i_marker_pos,
    input  logic [MLEN_W-1:0] i_marker_len,
    input  logic              i_final_req,
    input  logic [POS_W-1:0]  i_restored_len,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_summary,
    output logic [POS_W-1:0]  o_boundary_pos,
    output logic [CNT_W-1:0]  o_boundary_count,
    output logic [POS_W-1:0]  o_snapshot_pos,
    output logic              o_system_found,
    output logic              o_run_end
);

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    ctbf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_token        (i_token),
        .i_marker_set   (i_marker_set),
        .i_marker_index (i_marker_index),
        .i_marker_pos   (i_marker_pos),
        .i_marker_len   (i_marker_len),
        .i_final_req    (i_final_req),
        .i_restored_len (i_restored_len),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    ctbf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_summary     (o_is_summary),
        .o_boundary_pos   (o_boundary_pos),
        .o_boundary_count (o_boundary_count),
        .o_snapshot_pos   (o_snapshot_pos),
        .o_system_found   (o_system_found),
        .o_run_end        (o_run_end)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_boundary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_summary) |->
            (o_system_found && (o_boundary_pos != '0) && (o_boundary_count != '0)))
        else $error("Boundary item without system prefix or position.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_boundary_pos)
            && $stable(o_is_summary)))
        else $error("Stalled result item changed.");
`endif

endmodule

// ===== test/chat_turn_boundary_finder_unit_test.sv =====
// ----------------------------------------------------------------------------
// chat_turn_boundary_finder_unit_test: self-checking bench for the finder
// Loads marker tables and streams prompts built from those markers, noise and
// broken sequences, predicts every boundary and summary item in a scoreboard
// and compares them field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chat_turn_boundary_finder_unit_test;
    import ctbf_pkg::*;

    typedef struct {
        bit                mode;
        bit [TOK_W-1:0]    token;
        bit [SET_W-1:0]    mset;
        bit [MIDX_W-1:0]   midx;
        bit [MPOS_W-1:0]   mpos;
        bit [MLEN_W-1:0]   mlen;
        bit                fin;
        bit [POS_W-1:0]    restored;
    } tok_item_t;

    typedef struct {
        bit             is_sum;
        bit [POS_W-1:0] bpos;
        bit [CNT_W-1:0] cnt;
        bit [POS_W-1:0] snap;
        bit             sys;
        bit             rend;
    } turn_res_t;

    class boundary_board;
        bit [TOK_W-1:0] mtok[NSEQ*MAX_SEQ_LEN];
        int unsigned    mlen[NSEQ];
        bit [TOK_W-1:0] win[WIN_DEPTH];
        t_phase         ph;
        int unsigned    pc, cur, cnt, rb0, rb1, poff, pidx, nres;
        turn_res_t      pending[$];
        int             errors, checked, bounds, summaries;

        function void clear_scan();
            foreach (win[k]) win[k] = '0;
            ph = PH_SYS;
            pc = 0; cur = 0; cnt = 0; rb0 = 0; rb1 = 0; poff = 0; pidx = 0;
        endfunction

        function new();
            foreach (mtok[k]) mtok[k] = '0;
            foreach (mlen[k]) mlen[k] = 0;
            clear_scan();
        endfunction

        function bit seq_hit(int unsigned p, int unsigned id);
            for (int unsigned t = 0; t < mlen[id]; t++) begin
                if (win[(p + t) % WIN_DEPTH] != mtok[id*MAX_SEQ_LEN + t]) return 0;
            end
            return 1;
        endfunction

        function void add_res(bit s, int unsigned b, int unsigned c, int unsigned sn,
                              bit sy, bit e);
            turn_res_t r;
            r.is_sum = s; r.bpos = b; r.cnt = c; r.snap = sn; r.sys = sy; r.rend = e;
            pending.insert(pending.size(), r);
            nres++;
        endfunction

        function void next_probe();
            pidx++;
            if (pidx >= ROLE_SEQS) begin
                pidx = 0;
                poff++;
            end
        endfunction

        function void settle(bit fin);
            int unsigned id, len, p, b;
            int hit;
            bit decided;
            forever begin
                if (ph == PH_END) begin
                    hit = -1;
                    decided = 1;
                    if (cur >= pc) begin
                        if (fin) ph = PH_DONE;
                        return;
                    end
                    for (int unsigned i = 0; i < ROLE_SEQS; i++) begin
                        id = 1 + i;
                        len = mlen[id];
                        if (len == 0) continue;
                        if (cur + len > pc) begin
                            if (fin) continue;
                            decided = 0;
                            break;
                        end
                        if (seq_hit(cur, id)) begin
                            hit = id;
                            break;
                        end
                    end
                    if (hit >= 0) begin
                        cur += mlen[hit];
                        poff = 0;
                        pidx = 0;
                        ph = PH_PROBE;
                        continue;
                    end
                    if (!decided) return;
                    cur++;
                end else if (ph == PH_PROBE) begin
                    if (poff >= PROBE_SKIPS) begin
                        ph = PH_DONE;
                        return;
                    end
                    id = 1 + ROLE_SEQS + pidx;
                    len = mlen[id];
                    p = cur + poff;
                    if (len == 0) begin
                        next_probe();
                        continue;
                    end
                    if (p + len > pc) begin
                        if (!fin) return;
                        next_probe();
                        continue;
                    end
                    if (seq_hit(p, id)) begin
                        b = p + len;
                        if (cnt < 'hFFFF) cnt++;
                        rb1 = rb0;
                        rb0 = b;
                        if (nres < MAX_RESULTS - 1) add_res(0, b, cnt, 0, 1, 0);
                        cur = b;
                        ph = PH_END;
                        continue;
                    end
                    next_probe();
                end else begin
                    return;
                end
            end
        endfunction

        function void note_item(tok_item_t it);
            int unsigned id, target, snap;
            nres = 0;
            if (it.mode == 0) begin
                if (it.mset == SET_SYS) begin
                    if (it.midx != 0) return;
                    id = 0;
                end else if (it.mset == SET_END || it.mset == SET_ROLE) begin
                    if (it.midx >= ROLE_SEQS) return;
                    id = (it.mset == SET_END ? 1 : 1 + ROLE_SEQS) + it.midx;
                end else begin
                    return;
                end
                mlen[id] = it.mlen > MAX_SEQ_LEN ? MAX_SEQ_LEN : it.mlen;
                if (it.mpos < MAX_SEQ_LEN) mtok[id*MAX_SEQ_LEN + it.mpos] = it.token;
                return;
            end
            if (pc < MAX_PROMPT) begin
                win[pc % WIN_DEPTH] = it.token;
                pc++;
                if (ph == PH_SYS && mlen[0] > 0 && pc >= mlen[0]
                        && seq_hit(pc - mlen[0], 0)) begin
                    cur = pc;
                    ph = PH_END;
                end
                settle(it.fin);
            end else if (it.fin) begin
                settle(1);
            end
            if (it.fin) begin
                target = 0;
                snap = 0;
                if (cnt >= 2) target = rb1;
                else if (cnt == 1) target = rb0;
                if (cnt > 0 && target > it.restored) snap = target;
                add_res(1, 0, cnt, snap, ph != PH_SYS, 1);
                clear_scan();
            end
        endfunction

        function void check_result(turn_res_t got);
            turn_res_t want;
            bit bad;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result item, pos=%0d cnt=%0d",
                                           got.bpos, got.cnt);
                return;
            end
            want = pending.pop_front();
            if (want.is_sum) summaries++;
            else bounds++;
            bad = (got.is_sum != want.is_sum) || (got.bpos != want.bpos)
                || (got.cnt != want.cnt) || (got.snap != want.snap)
                || (got.sys != want.sys) || (got.rend != want.rend);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: exp sum=%0d pos=%0d cnt=%0d snap=%0d sys=%0d end=%0d,",
                              " got sum=%0d pos=%0d cnt=%0d snap=%0d sys=%0d end=%0d"},
                             want.is_sum, want.bpos, want.cnt, want.snap, want.sys,
                             want.rend, got.is_sum, got.bpos, got.cnt, got.snap,
                             got.sys, got.rend);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_mode = 1'b0;
    logic [TOK_W-1:0]  i_token = '0;
    logic [SET_W-1:0]  i_marker_set = '0;
    logic [MIDX_W-1:0] i_marker_index = '0;
    logic [MPOS_W-1:0] i_marker_pos = '0;
    logic [MLEN_W-1:0] i_marker_len = '0;
    logic              i_final_req = 1'b0;
    logic [POS_W-1:0]  i_restored_len = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_is_summary;
    logic [POS_W-1:0]  o_boundary_pos;
    logic [CNT_W-1:0]  o_boundary_count;
    logic [POS_W-1:0]  o_snapshot_pos;
    logic              o_system_found;
    logic              o_run_end;

    chat_turn_boundary_finder_unit uut (.*);

    boundary_board board = new();
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;
    int            sent = 0;
    int            quiet = 0;
    bit [TOK_W-1:0] token_pool[8];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        turn_res_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.is_sum = o_is_summary;
            got.bpos = o_boundary_pos;
            got.cnt = o_boundary_count;
            got.snap = o_snapshot_pos;
            got.sys = o_system_found;
            got.rend = o_run_end;
            board.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 3000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    task automatic push_item(tok_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= it.mode;
        i_token <= it.token;
        i_marker_set <= it.mset;
        i_marker_index <= it.midx;
        i_marker_pos <= it.mpos;
        i_marker_len <= it.mlen;
        i_final_req <= it.fin;
        i_restored_len <= it.restored;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(it);
        sent++;
    endtask

    task automatic push_load(bit [1:0] mset, bit [1:0] midx, bit [1:0] mpos,
                             bit [2:0] mlen, bit [TOK_W-1:0] tok);
        tok_item_t it;
        it.mode = 0; it.token = tok; it.mset = mset; it.midx = midx; it.mpos = mpos;
        it.mlen = mlen; it.fin = $urandom_range(0, 1); it.restored = $urandom_range(0, 65536);
        push_item(it);
    endtask

    task automatic push_token(bit [TOK_W-1:0] tok, bit fin, bit [POS_W-1:0] rest);
        tok_item_t it;
        it.mode = 1; it.token = tok; it.fin = fin; it.restored = rest;
        it.mset = $urandom_range(0, 3); it.midx = $urandom_range(0, 3);
        it.mpos = $urandom_range(0, 3); it.mlen = $urandom_range(0, 7);
        push_item(it);
    endtask

    // Writes all four token slots of a sequence so no unwritten entry is read.
    task automatic load_seq(int id, int len);
        bit [1:0] mset, midx;
        mset = id == 0 ? SET_SYS : (id <= ROLE_SEQS ? SET_END : SET_ROLE);
        midx = id == 0 ? 0 : (id <= ROLE_SEQS ? id - 1 : id - 1 - ROLE_SEQS);
        for (int k = 0; k < MAX_SEQ_LEN; k++)
            push_load(mset, midx, k, len, token_pool[$urandom_range(0, 7)]);
    endtask

    task automatic random_table();
        for (int id = 0; id < NSEQ; id++)
            load_seq(id, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4));
    endtask

    function automatic bit [TOK_W-1:0] pick_token();
        return $urandom_range(0, 3) == 0 ? TOK_W'($urandom) : token_pool[$urandom_range(0, 7)];
    endfunction

    task automatic append_seq(ref bit [TOK_W-1:0] q[$], input int id, input bit cut);
        int n;
        n = board.mlen[id];
        if (cut && n > 1) n = $urandom_range(1, n - 1);
        for (int k = 0; k < n; k++) q.insert(q.size(), board.mtok[id*MAX_SEQ_LEN + k]);
    endtask

    task automatic run_prompt(int segs, int noise);
        bit [TOK_W-1:0] q[$];
        bit [POS_W-1:0] rest;
        int lp;
        if ($urandom_range(0, 3) == 0) q.insert(q.size(), pick_token());
        if ($urandom_range(0, 9) != 0) append_seq(q, 0, $urandom_range(0, 19) == 0);
        for (int s = 0; s < segs; s++) begin
            repeat ($urandom_range(0, noise)) q.insert(q.size(), pick_token());
            append_seq(q, 1 + $urandom_range(0, ROLE_SEQS - 1), $urandom_range(0, 9) == 0);
            repeat ($urandom_range(0, noise > 4 ? 4 : noise)) q.insert(q.size(), pick_token());
            append_seq(q, 1 + ROLE_SEQS + $urandom_range(0, ROLE_SEQS - 1),
                       $urandom_range(0, 9) == 0);
        end
        if (q.size() == 0) q.insert(q.size(), pick_token());
        case ($urandom_range(0, 3))
            0: rest = 0;
            1: rest = 17'd65536;
            default: rest = $urandom_range(0, q.size());
        endcase
        lp = $urandom_range(0, 15) == 0 ? $urandom_range(0, q.size() - 1) : -1;
        foreach (q[k]) begin
            if (k == lp) load_seq($urandom_range(0, NSEQ - 1), $urandom_range(0, 4));
            push_token(q[k], k == q.size() - 1, rest);
        end
    endtask

    initial begin
        bit held;
        held = 1'b0;
        foreach (token_pool[k]) token_pool[k] = TOK_W'($urandom);
        token_pool[0] = '0;
        token_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full table, bad load targets, saturating length, edge prompts.
        for (int id = 0; id < NSEQ; id++) load_seq(id, 1 + id % MAX_SEQ_LEN);
        push_load(2'd3, 0, 0, 3'd2, '1);
        push_load(SET_SYS, 1, 0, 3'd1, '1);
        push_load(SET_END, 3, 0, 3'd1, '1);
        push_load(SET_ROLE, 3, 3, 3'd7, '1);
        push_load(SET_ROLE, 2, 3, 3'd7, token_pool[2]);
        push_token(token_pool[3], 1'b1, 0);
        run_prompt(3, 1);
        run_prompt(8, 0);
        run_prompt(2, 6);

        while (sent < 340) begin
            if ($urandom_range(0, 7) == 0) random_table();
            if (!held && sent > 200) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            run_prompt($urandom_range(0, 6), $urandom_range(0, 6));
        end
        i_in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        idle_on = 1'b0;
        random_table();
        repeat (4) run_prompt($urandom_range(1, 5), $urandom_range(0, 3));
        i_in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("Covered %0d input items, %0d boundary items and %0d summaries checked.",
                 sent, board.bounds, board.summaries);
        $display("Mismatches: %0d, unmatched leftovers: %0d.", board.errors,
                 board.pending.size());
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
